/* rtl/lssa_pkg.sv */
// ----------------------------------------------------------------------------
// lssa_pkg: linear scan slot allocator package
// Shared widths and parameter defaults for the allocator and its channels.
// ----------------------------------------------------------------------------
package lssa_pkg;

    // default slot count and position width
    localparam int LSSA_NUM_SLOTS = 7;
    localparam int LSSA_POS_BITS  = 16;

    // fixed field widths of the channels
    localparam int ID_W   = 16;
    localparam int POS_W  = 16;
    localparam int SLOT_W = 3;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SLOT_W-1:0] slot_t;

endpackage

/* rtl/lssa_in_if.sv */
// ----------------------------------------------------------------------------
// lssa_in_if: interval channel
// One live interval per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lssa_in_if
    import lssa_pkg::*;
;
    logic valid;
    logic ready;
    logic first_of_function;
    id_t  interval_id;
    pos_t def_position;
    pos_t last_use_position;

    modport source
    (
        output valid,
        input  ready,
        output first_of_function,
        output interval_id,
        output def_position,
        output last_use_position
    );

    modport sink
    (
        input  valid,
        output ready,
        input  first_of_function,
        input  interval_id,
        input  def_position,
        input  last_use_position
    );
endinterface

/* rtl/lssa_out_if.sv */
// ----------------------------------------------------------------------------
// lssa_out_if: allocation result channel
// One slot decision per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lssa_out_if
    import lssa_pkg::*;
;
    logic  valid;
    logic  ready;
    slot_t assigned_slot;
    logic  self_spilled;
    logic  victim_valid;
    id_t   victim_id;
    slot_t pressure_max;

    modport source
    (
        output valid,
        input  ready,
        output assigned_slot,
        output self_spilled,
        output victim_valid,
        output victim_id,
        output pressure_max
    );

    modport sink
    (
        input  valid,
        output ready,
        input  assigned_slot,
        input  self_spilled,
        input  victim_valid,
        input  victim_id,
        input  pressure_max
    );
endinterface

/* rtl/lssa_pick.sv */
// ----------------------------------------------------------------------------
// lssa_pick: slot selection
// First-fit search over the regular slots and a tournament tree that finds
// the slot with the greatest last use, lowest index on a tie.
// ----------------------------------------------------------------------------
module lssa_pick
    import lssa_pkg::*;
#(
    parameter int NUM_SLOTS = LSSA_NUM_SLOTS,
    parameter int PW        = LSSA_POS_BITS,
    localparam int IDX_W    = $clog2(NUM_SLOTS)
)
(
    input  logic [NUM_SLOTS-1:0]         slot_valid,
    input  logic [NUM_SLOTS-1:0][PW-1:0] slot_end,
    input  logic [PW-1:0]                def_pos,
    input  logic [PW-1:0]                new_end,
    output logic                         found,
    output logic [IDX_W-1:0]             free_idx,
    output logic [IDX_W-1:0]             max_idx
);

    localparam int LEAVES = 2 ** IDX_W;

    logic [NUM_SLOTS-2:0]  fit;
    logic [PW-1:0]         node_end [1:2*LEAVES-1];
    logic [IDX_W-1:0]      node_idx [1:2*LEAVES-1];

    // a regular slot fits when empty or its owner is dead at the definition
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS - 1; i++)
        begin
            fit[i] = !slot_valid[i] || (def_pos >= slot_end[i]);
        end
    end

    // priority encoder, lowest fitting slot
    always_comb
    begin
        free_idx = '0;
        for (int i = NUM_SLOTS - 2; i >= 0; i--)
        begin
            if (fit[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign found = |fit;

    // argmax tree; the last slot carries the incoming interval, padding leaves
    // have end zero and higher index so they never win
    always_comb
    begin
        for (int n = 1; n < 2 * LEAVES; n++)
        begin
            node_end[n] = '0;
            node_idx[n] = '0;
        end
        for (int i = 0; i < LEAVES; i++)
        begin
            node_idx[LEAVES+i] = IDX_W'(i);
            if (i < NUM_SLOTS - 1)
            begin
                node_end[LEAVES+i] = slot_end[i];
            end
            else if (i == NUM_SLOTS - 1)
            begin
                node_end[LEAVES+i] = new_end;
            end
        end
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            if (node_end[2*n] < node_end[2*n+1])
            begin
                node_end[n] = node_end[2*n+1];
                node_idx[n] = node_idx[2*n+1];
            end
            else
            begin
                node_end[n] = node_end[2*n];
                node_idx[n] = node_idx[2*n];
            end
        end
    end

    assign max_idx = node_idx[1];

endmodule

/* rtl/linear_scan_slot_allocator.sv */
// ----------------------------------------------------------------------------
// linear_scan_slot_allocator: linear scan slot allocation
// An accepted interval passes through the input register, then the result
// register. Throughput: one interval per cycle while results.ready holds;
// slot state is updated in the cycle the result is registered, so
// back-to-back intervals see it directly.
// Reset: slots empty, pressure zero, both pipeline stages empty.
// ----------------------------------------------------------------------------
module linear_scan_slot_allocator
    import lssa_pkg::*;
#(
    parameter int NUM_SLOTS = LSSA_NUM_SLOTS,
    parameter int POS_BITS  = LSSA_POS_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    lssa_in_if.sink          intervals,
    lssa_out_if.source       results
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int PW    = (POS_BITS < POS_W) ? POS_BITS : POS_W;
    localparam int LAST  = NUM_SLOTS - 1;

    // input register
    logic                          s1_valid_reg;
    logic                          s1_first_reg;
    id_t                           s1_id_reg;
    logic [PW-1:0]                 s1_def_reg;
    logic [PW-1:0]                 s1_end_reg;

    // slot state
    logic [NUM_SLOTS-1:0]          slot_valid_reg, slot_valid_next;
    id_t                           slot_owner_reg [NUM_SLOTS];
    id_t                           slot_owner_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0][PW-1:0]  slot_end_reg, slot_end_next;
    logic [IDX_W-1:0]              pressure_reg, pressure_next;

    // result register
    logic                          out_valid_reg;
    logic [IDX_W-1:0]              assigned_reg, assigned_next;
    logic                          self_reg, self_next;
    logic                          victim_reg, victim_next;
    id_t                           victim_id_reg, victim_id_next;

    logic                          s1_load;
    logic                          s2_load;
    logic [NUM_SLOTS-1:0]          cur_valid;
    logic                          found;
    logic [IDX_W-1:0]              free_idx;
    logic [IDX_W-1:0]              max_idx;

    // pipeline handshake
    assign s2_load         = s1_valid_reg && (!out_valid_reg || results.ready);
    assign intervals.ready = !s1_valid_reg || s2_load;
    assign s1_load         = intervals.valid && intervals.ready;

    // function start empties every slot
    assign cur_valid = s1_first_reg ? '0 : slot_valid_reg;

    lssa_pick #(
        .NUM_SLOTS (NUM_SLOTS),
        .PW        (PW)
    ) u_pick (
        .slot_valid (cur_valid),
        .slot_end   (slot_end_reg),
        .def_pos    (s1_def_reg),
        .new_end    (s1_end_reg),
        .found      (found),
        .free_idx   (free_idx),
        .max_idx    (max_idx)
    );

    // slot update and result
    always_comb
    begin
        slot_valid_next = cur_valid;
        slot_end_next   = slot_end_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_owner_next[i] = slot_owner_reg[i];
        end
        pressure_next  = s1_first_reg ? '0 : pressure_reg;
        assigned_next  = free_idx;
        self_next      = 1'b0;
        victim_next    = 1'b0;
        victim_id_next = '0;

        if (found)
        begin
            slot_valid_next[free_idx] = 1'b1;
            slot_owner_next[free_idx] = s1_id_reg;
            slot_end_next[free_idx]   = s1_end_reg;
            if (free_idx > pressure_next)
            begin
                pressure_next = free_idx;
            end
        end
        else
        begin
            slot_valid_next[LAST] = 1'b1;
            assigned_next         = max_idx;
            pressure_next         = IDX_W'(LAST);
            if (max_idx == IDX_W'(LAST))
            begin
                // the new interval has the farthest end and spills itself
                self_next             = 1'b1;
                slot_owner_next[LAST] = s1_id_reg;
                slot_end_next[LAST]   = s1_end_reg;
            end
            else
            begin
                // swap: new interval takes the victim slot, victim goes last
                victim_next              = 1'b1;
                victim_id_next           = slot_owner_reg[max_idx];
                slot_owner_next[max_idx] = s1_id_reg;
                slot_end_next[max_idx]   = s1_end_reg;
                slot_owner_next[LAST]    = slot_owner_reg[max_idx];
                slot_end_next[LAST]      = slot_end_reg[max_idx];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            pressure_reg   <= '0;
        end
        else
        begin
            if (intervals.ready)
            begin
                s1_valid_reg <= intervals.valid;
            end
            if (s2_load)
            begin
                out_valid_reg  <= 1'b1;
                slot_valid_reg <= slot_valid_next;
                pressure_reg   <= pressure_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_first_reg <= intervals.first_of_function;
            s1_id_reg    <= intervals.interval_id;
            s1_def_reg   <= PW'(intervals.def_position);
            s1_end_reg   <= PW'(intervals.last_use_position);
        end
        if (s2_load)
        begin
            slot_end_reg <= slot_end_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_owner_reg[i] <= slot_owner_next[i];
            end
            assigned_reg  <= assigned_next;
            self_reg      <= self_next;
            victim_reg    <= victim_next;
            victim_id_reg <= victim_id_next;
        end
    end

    // result channel
    assign results.valid         = out_valid_reg;
    assign results.assigned_slot = SLOT_W'(assigned_reg);
    assign results.self_spilled  = self_reg;
    assign results.victim_valid  = victim_reg;
    assign results.victim_id     = victim_id_reg;
    assign results.pressure_max  = SLOT_W'(pressure_reg);

`ifndef SYNTHESIS
    // a self spill never reports a victim
    a_spill_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(self_reg && victim_reg))
        else $error("self spill and victim both set");

    // victim id is zero unless a victim is reported
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !victim_reg) |-> (victim_id_reg == '0))
        else $error("stray victim id");

    // a self spill lands in the last slot
    a_self_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && self_reg) |-> (assigned_reg == IDX_W'(LAST)))
        else $error("self spill not in last slot");

    // slot zero is always occupied after an item is handled
    a_slot0_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> slot_valid_reg[0])
        else $error("slot zero empty after allocation");
`endif

endmodule
